// ----- hdl/bmhq_pkg.sv -----
// Shared types and codes for the binary min-heap priority queue.
package bmhq_pkg;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic        func;
      logic [63:0] payload_word;
      logic [7:0]  cost;
      logic [7:0]  estimate;
      logic [3:0]  position_tag;
   } req_type;

   typedef struct packed {
      logic        pop_valid;
      logic [63:0] out_payload;
      logic [7:0]  out_cost;
      logic [7:0]  out_estimate;
      logic [3:0]  out_tag;
      logic [1:0]  status;
      logic        is_empty_now;
      logic [10:0] entry_count;
   } rsp_type;

   // one heap slot: key cost + estimate, plus tag and payload
   typedef struct packed {
      logic [7:0]  cost;
      logic [7:0]  estimate;
      logic [3:0]  tag;
      logic [63:0] payload;
   } entry_type;

   function automatic logic [8:0] prio_of(entry_type e);
      prio_of = {1'b0, e.cost} + {1'b0, e.estimate};
   endfunction

endpackage

// ----- hdl/bmhq_mem.sv -----
// Heap entry storage: one write port and two registered read ports.
module bmhq_mem #(
   parameter int AW    = 10,
   parameter int DEPTH = 1024
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  bmhq_pkg::entry_type  wr_data,
   input  logic [AW-1:0]        rd_addr_a,
   input  logic [AW-1:0]        rd_addr_b,
   output bmhq_pkg::entry_type  rd_data_a,
   output bmhq_pkg::entry_type  rd_data_b
);

   bmhq_pkg::entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ----- hdl/binary_min_heap_queue.sv -----
// Top level of the binary min-heap priority queue.
// One request at a time: busy stays high from start until the response strobe.
// A push climbs levels from the new last slot and a pop descends levels from
// the root. The pace is set by the registered reads of the entry memory, which
// each sift step reads and writes once. The response is shown for one cycle
// on rsp_valid and the receiver cannot stall it.
module binary_min_heap_queue #(
   parameter int CAPACITY = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bmhq_pkg::req_type req_data,
   output logic              rsp_valid,
   output bmhq_pkg::rsp_type rsp_data
);

   localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_UPRD  = 3'd1;
   localparam logic [2:0] ST_UPCMP = 3'd2;
   localparam logic [2:0] ST_DNRD  = 3'd3;
   localparam logic [2:0] ST_DNCMP = 3'd4;
   localparam logic [2:0] ST_ROOT  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        pos_ff, pos_in;
   bmhq_pkg::entry_type  cur_ff, cur_in;
   bmhq_pkg::rsp_type    rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr_a, rd_addr_b;
   bmhq_pkg::entry_type  wr_data, rd_a, rd_b;

   bmhq_mem #(.AW(AW), .DEPTH(CAPACITY)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr_a(rd_addr_a), .rd_addr_b(rd_addr_b),
      .rd_data_a(rd_a), .rd_data_b(rd_b)
   );

   logic [CW:0] lft, rgt;
   logic [CW-1:0] par;
   logic        l_ok, r_ok, take_l, take_r;
   logic [8:0]  p_best;

   always_comb begin
      par  = (pos_ff - CW'(1)) >> 1;
      lft  = {pos_ff, 1'b1};
      rgt  = {pos_ff, 1'b0} + (CW+1)'(2);
      l_ok = lft < {1'b0, count_ff};
      r_ok = rgt < {1'b0, count_ff};
      take_l = l_ok && (bmhq_pkg::prio_of(rd_a) < bmhq_pkg::prio_of(cur_ff));
      p_best = take_l ? bmhq_pkg::prio_of(rd_a) : bmhq_pkg::prio_of(cur_ff);
      take_r = r_ok && (bmhq_pkg::prio_of(rd_b) < p_best);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = pos_ff[AW-1:0];
      wr_data      = cur_ff;
      rd_addr_a    = par[AW-1:0];
      rd_addr_b    = par[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr_a = '0;
            rd_addr_b = AW'(count_ff - CW'(1));
            if (start && !rsp_valid_ff) begin
               rsp_in = '0;
               cur_in = '{cost: req_data.cost, estimate: req_data.estimate,
                          tag: req_data.position_tag, payload: req_data.payload_word};
               if (req_data.func == bmhq_pkg::FUNC_PUSH) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     rsp_in.status = bmhq_pkg::STATUS_FULL;
                     state_in = ST_DONE;
                  end else begin
                     pos_in   = count_ff;
                     count_in = count_ff + CW'(1);
                     state_in = ST_UPRD;
                  end
               end else if (count_ff == '0) begin
                  rsp_in.status = bmhq_pkg::STATUS_EMPTY;
                  state_in = ST_DONE;
               end else begin
                  count_in = count_ff - CW'(1);
                  pos_in   = '0;
                  state_in = ST_ROOT;
               end
            end
         end
         ST_UPRD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_UPCMP;
            end
         end
         ST_UPCMP: begin
            if (bmhq_pkg::prio_of(cur_ff) < bmhq_pkg::prio_of(rd_a)) begin
               wr_en    = 1'b1;
               wr_data  = rd_a;
               pos_in   = par;
               state_in = ST_UPRD;
            end else begin
               wr_en    = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_ROOT: begin
            rsp_in.pop_valid    = 1'b1;
            rsp_in.out_payload  = rd_a.payload;
            rsp_in.out_cost     = rd_a.cost;
            rsp_in.out_estimate = rd_a.estimate;
            rsp_in.out_tag      = rd_a.tag;
            cur_in   = rd_b;
            state_in = ST_DNRD;
         end
         ST_DNRD: begin
            rd_addr_a = lft[AW-1:0];
            rd_addr_b = rgt[AW-1:0];
            state_in  = ST_DNCMP;
         end
         ST_DNCMP: begin
            wr_en = 1'b1;
            if (take_r) begin
               wr_data  = rd_b;
               pos_in   = rgt[CW-1:0];
               state_in = ST_DNRD;
            end else if (take_l) begin
               wr_data  = rd_a;
               pos_in   = lft[CW-1:0];
               state_in = ST_DNRD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_in.is_empty_now = (count_ff == '0);
            rsp_in.entry_count  = 11'(count_ff);
            rsp_valid_in        = 1'b1;
            state_in            = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_UPRD) begin
         rd_addr_a = par[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff <= pos_in;
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/bmhq_checker.sv -----
// Port-level assertions for the heap queue, bound to the top level.
module bmhq_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input bmhq_pkg::rsp_type rsp_data
);

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted request did not raise busy");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response while not busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe longer than one cycle");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty_now == (rsp_data.entry_count == 11'd0)))
      else $error("empty flag disagrees with count");

   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pop_valid |-> rsp_data.status == bmhq_pkg::STATUS_OK)
      else $error("popped entry with error status");

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);

// ----- sim/binary_min_heap_queue_checker.sv -----
// Checker for the min-heap queue: predicts each response from accepted requests and compares.
module binary_min_heap_queue_checker #(
   parameter int CAPACITY = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  bmhq_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  bmhq_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count,
   output int                pop_hits,
   output int                empty_hits,
   output int                full_hits
);
   timeunit 1ns;
   timeprecision 1ps;

   bmhq_pkg::entry_type slots[CAPACITY];
   int                  fill;
   bmhq_pkg::rsp_type   expected_rsps[$];

   function automatic int weight(bmhq_pkg::entry_type e);
      return int'(e.cost) + int'(e.estimate);
   endfunction

   task automatic exchange(int a, int b);
      bmhq_pkg::entry_type t;
      t = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
   endtask

   task automatic apply_request(bmhq_pkg::req_type r);
      bmhq_pkg::rsp_type   o;
      bmhq_pkg::entry_type e;
      int        pos, up, l, rt, best;
      o = '0;
      o.status = bmhq_pkg::STATUS_OK;
      if (r.func == bmhq_pkg::FUNC_PUSH) begin
         if (fill >= CAPACITY) begin
            o.status = bmhq_pkg::STATUS_FULL;
         end else begin
            e.cost = r.cost;
            e.estimate = r.estimate;
            e.tag = r.position_tag;
            e.payload = r.payload_word;
            slots[fill] = e;
            pos = fill;
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (weight(slots[pos]) < weight(slots[up])) begin
                  exchange(pos, up);
                  pos = up;
               end else begin
                  break;
               end
            end
            fill++;
         end
      end else if (fill == 0) begin
         o.status = bmhq_pkg::STATUS_EMPTY;
      end else begin
         o.pop_valid = 1'b1;
         o.out_payload = slots[0].payload;
         o.out_cost = slots[0].cost;
         o.out_estimate = slots[0].estimate;
         o.out_tag = slots[0].tag;
         fill--;
         slots[0] = slots[fill];
         pos = 0;
         forever begin
            l = 2 * pos + 1;
            rt = 2 * pos + 2;
            best = pos;
            if (l < fill && weight(slots[l]) < weight(slots[best])) best = l;
            if (rt < fill && weight(slots[rt]) < weight(slots[best])) best = rt;
            if (best == pos) break;
            exchange(pos, best);
            pos = best;
         end
      end
      o.is_empty_now = (fill == 0);
      o.entry_count = 11'(fill);
      expected_rsps.push_back(o);
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      fill = 0;
      pop_hits = 0;
      empty_hits = 0;
      full_hits = 0;
   end

   always @(posedge clock) begin
      bmhq_pkg::rsp_type w;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            report("unexpected response", 64'(rsp_data.entry_count), 64'(0));
         end else begin
            w = expected_rsps.pop_front();
            if (rsp_data.pop_valid !== w.pop_valid)
               report("pop_valid", 64'(rsp_data.pop_valid), 64'(w.pop_valid));
            if (rsp_data.out_payload !== w.out_payload)
               report("out_payload", rsp_data.out_payload, w.out_payload);
            if (rsp_data.out_cost !== w.out_cost)
               report("out_cost", 64'(rsp_data.out_cost), 64'(w.out_cost));
            if (rsp_data.out_estimate !== w.out_estimate)
               report("out_estimate", 64'(rsp_data.out_estimate), 64'(w.out_estimate));
            if (rsp_data.out_tag !== w.out_tag)
               report("out_tag", 64'(rsp_data.out_tag), 64'(w.out_tag));
            if (rsp_data.status !== w.status)
               report("status", 64'(rsp_data.status), 64'(w.status));
            if (rsp_data.is_empty_now !== w.is_empty_now)
               report("is_empty_now", 64'(rsp_data.is_empty_now), 64'(w.is_empty_now));
            if (rsp_data.entry_count !== w.entry_count)
               report("entry_count", 64'(rsp_data.entry_count), 64'(w.entry_count));
            if (w.pop_valid) pop_hits++;
            if (w.status == bmhq_pkg::STATUS_EMPTY) empty_hits++;
            if (w.status == bmhq_pkg::STATUS_FULL) full_hits++;
         end
      end
      if (!reset && start && !busy)
         apply_request(req_data);
      pending_count = expected_rsps.size();
   end

endmodule

// ----- sim/binary_min_heap_queue_tb.sv -----
// Testbench top for the min-heap queue: drives requests and gives the verdict.
module binary_min_heap_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 256;
   localparam int CYCLE_LIMIT = 600000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   bmhq_pkg::req_type req_data;
   logic              rsp_valid;
   bmhq_pkg::rsp_type rsp_data;
   int      fail_count, pending_count, pop_hits, empty_hits, full_hits;
   int      cycles;
   int      sent;
   int      burst_left;

   binary_min_heap_queue #(.CAPACITY(CAPACITY)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   binary_min_heap_queue_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .pop_hits(pop_hits), .empty_hits(empty_hits), .full_hits(full_hits)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // present one request, hold until accepted, then drop start unless gapless
   task automatic send(logic f, logic [63:0] p, logic [7:0] c, logic [7:0] e,
                       logic [3:0] t);
      int gap;
      req_data.func <= f;
      req_data.payload_word <= p;
      req_data.cost <= c;
      req_data.estimate <= e;
      req_data.position_tag <= t;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic push_random(int span);
      logic [63:0] p;
      p = {$urandom, $urandom};
      send(bmhq_pkg::FUNC_PUSH, p, 8'($urandom_range(0, span)),
           8'($urandom_range(0, span)), 4'($urandom));
   endtask

   task automatic drain_wait;
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0 || busy) @(negedge clock);
   endtask

   initial begin
      int mode, n;
      cycles = 0;
      sent = 0;
      burst_left = 0;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send(bmhq_pkg::FUNC_POP, '0, 8'd0, 8'd0, 4'd0);
      send(bmhq_pkg::FUNC_PUSH, '1, 8'hFF, 8'hFF, 4'hF);
      send(bmhq_pkg::FUNC_PUSH, '0, 8'h00, 8'h00, 4'h0);
      send(bmhq_pkg::FUNC_PUSH, 64'hA5A5_5A5A_0F0F_F0F0, 8'h80, 8'h01, 4'h5);
      send(bmhq_pkg::FUNC_PUSH, 64'h5A5A_A5A5_F0F0_0F0F, 8'h01, 8'h80, 4'hA);
      send(bmhq_pkg::FUNC_PUSH, 64'h1, 8'h40, 8'h41, 4'h3);
      send(bmhq_pkg::FUNC_PUSH, 64'h8000_0000_0000_0000, 8'hFF, 8'h00, 4'h9);
      send(bmhq_pkg::FUNC_PUSH, 64'h2, 8'h00, 8'hFF, 4'h6);
      repeat (8) send(bmhq_pkg::FUNC_POP, '0, 8'd0, 8'd0, 4'd0);
      drain_wait();

      // fill to capacity, overflow, then drain past empty
      for (int i = 0; i < CAPACITY; i++) push_random(i % 3 == 0 ? 255 : 7);
      repeat (3) push_random(255);
      drain_wait();
      for (int i = 0; i < CAPACITY + 2; i++)
         send(bmhq_pkg::FUNC_POP, '0, 8'd0, 8'd0, 4'd0);
      drain_wait();

      while (sent < 1050) begin
         mode = $urandom_range(0, 9);
         n = $urandom_range(1, 20);
         for (int i = 0; i < n; i++) begin
            if (mode < 6) begin
               if ($urandom_range(0, 2) != 0) push_random(mode < 3 ? 3 : 255);
               else send(bmhq_pkg::FUNC_POP, '0, 8'd0, 8'd0, 4'd0);
            end else if (mode < 8) begin
               push_random(255);
            end else begin
               send(bmhq_pkg::FUNC_POP, {$urandom, $urandom}, 8'($urandom),
                    8'($urandom), 4'($urandom));
            end
         end
      end
      drain_wait();
      repeat (40) @(negedge clock);

      $display("covered %0d requests: %0d pops returned, %0d empty pops, %0d full pushes",
               sent, pop_hits, empty_hits, full_hits);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
